/* rtl/mhpq_pkg.sv */
package mhpq_pkg;
   localparam int KeyWidth = 32;
   localparam int TagWidth = 16;
   localparam int EntryWidth = KeyWidth + TagWidth;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_BUILD  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_DELETE = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [KeyWidth-1:0] key;
      logic [TagWidth-1:0]        tag;
   } entry_type;
endpackage

/* rtl/mhpq_if.sv */
interface mhpq_req_if #(parameter int IndexWidth = 7);
   logic valid;
   logic ready;
   mhpq_pkg::command_type command;
   logic signed [mhpq_pkg::KeyWidth-1:0] key;
   logic [mhpq_pkg::TagWidth-1:0] tag;
   logic [IndexWidth-1:0] entry_index;
   modport source (output valid, command, key, tag, entry_index, input ready);
   modport sink (input valid, command, key, tag, entry_index, output ready);
endinterface

/* rtl/mhpq_rsp_if.sv */
interface mhpq_rsp_if #(parameter int IndexWidth = 7);
   logic valid;
   logic ready;
   logic signed [mhpq_pkg::KeyWidth-1:0] out_key;
   logic [mhpq_pkg::TagWidth-1:0] out_tag;
   logic [IndexWidth-1:0] entry_count;
   mhpq_pkg::status_type status;
   modport source (output valid, out_key, out_tag, entry_count, status, input ready);
   modport sink (input valid, out_key, out_tag, entry_count, status, output ready);
endinterface

/* rtl/max_heap_priority_queue_core.sv */
// Binary max-heap of CAPACITY entries (signed Q16.16 key, 16-bit tag) held in one
// single-port-read RAM with a registered read. Append writes the entry at the end of
// the heap; read fetches the entry at the given index. Build, and delete (last entry
// moved into the slot, then a full rebuild), sift down every parent from size/2 to 1;
// each sift step reads parent, left and right child (one read per cycle) and writes
// back up to two entries. One request is processed at a time; a new request is taken
// only once the response has been accepted.
module max_heap_priority_queue_core #(
   parameter int CAPACITY = 64
) (
   input logic clock,
   input logic reset,
   mhpq_req_if.sink   req,
   mhpq_rsp_if.source rsp
);
   localparam int AW = $clog2(CAPACITY);
   localparam int SW = $clog2(CAPACITY + 1);
   localparam int XW = SW + 1;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_RDWAIT = 11'b00000000010,
      S_MOVE   = 11'b00000000100,
      S_BSTART = 11'b00000001000,
      S_RP     = 11'b00000010000,
      S_RL     = 11'b00000100000,
      S_RR     = 11'b00001000000,
      S_CMP    = 11'b00010000000,
      S_WR2    = 11'b00100000000,
      S_RESP   = 11'b01000000000,
      S_MVWAIT = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [SW-1:0] size_ff, size_in;
   logic [SW-1:0] outer_ff, outer_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] big_ff, big_in;
   mhpq_pkg::entry_type par_ff, par_in, lc_ff, lc_in, rc_ff, rc_in;
   mhpq_pkg::entry_type ent_ff, ent_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::entry_type rsp_ent_ff, rsp_ent_in;
   logic [SW-1:0] rsp_cnt_ff, rsp_cnt_in;
   mhpq_pkg::status_type rsp_st_ff, rsp_st_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   mhpq_pkg::entry_type wr_data, rd_data;

   mhpq_ram #(.Width(mhpq_pkg::EntryWidth), .Depth(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [XW-1:0] lc_slot, rc_slot;
   logic [SW-1:0] slot_m1;
   assign lc_slot = {slot_ff, 1'b0};
   assign rc_slot = lc_slot + XW'(1);
   assign slot_m1 = slot_ff - SW'(1);

   function automatic logic [AW-1:0] adr(input logic [XW-1:0] s);
      logic [XW-1:0] t;
      t = s - XW'(1);
      return t[AW-1:0];
   endfunction

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_key = rsp_ent_ff.key;
   assign rsp.out_tag = rsp_ent_ff.tag;
   assign rsp.entry_count = rsp_cnt_ff;
   assign rsp.status = rsp_st_ff;

   always_comb begin
      state_in = state_ff;
      size_in = size_ff;
      outer_in = outer_ff;
      slot_in = slot_ff;
      big_in = big_ff;
      par_in = par_ff;
      lc_in = lc_ff;
      rc_in = rc_ff;
      ent_in = ent_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_ent_in = rsp_ent_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_st_in = rsp_st_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = ent_ff;
      rd_addr = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               ent_in.key = req.key;
               ent_in.tag = req.tag;
               idx_in = SW'(req.entry_index);
               rsp_ent_in = '0;
               rsp_st_in = mhpq_pkg::ST_OK;
               unique case (req.command)
                  mhpq_pkg::CMD_APPEND: begin
                     if (size_ff >= SW'(CAPACITY)) begin
                        rsp_st_in = mhpq_pkg::ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = size_ff[AW-1:0];
                        wr_data.key = req.key;
                        wr_data.tag = req.tag;
                        size_in = size_ff + SW'(1);
                     end
                     state_in = S_RESP;
                  end
                  mhpq_pkg::CMD_BUILD: state_in = S_BSTART;
                  default: begin
                     if (req.entry_index == '0 || SW'(req.entry_index) > size_ff) begin
                        rsp_st_in = mhpq_pkg::ST_BAD_INDEX;
                        state_in = S_RESP;
                     end else if (req.command == mhpq_pkg::CMD_READ) begin
                        rd_addr = adr(XW'(req.entry_index));
                        state_in = S_RDWAIT;
                     end else begin
                        rd_addr = adr(XW'(size_ff));
                        state_in = S_MVWAIT;
                     end
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            rsp_ent_in = rd_data;
            state_in = S_RESP;
         end
         S_MVWAIT: begin
            rd_addr = adr(XW'(size_ff));
            state_in = S_MOVE;
         end
         S_MOVE: begin
            wr_en = 1'b1;
            wr_addr = adr(XW'(idx_ff));
            wr_data = rd_data;
            size_in = size_ff - SW'(1);
            state_in = S_BSTART;
         end
         S_BSTART: begin
            outer_in = size_ff >> 1;
            slot_in = size_ff >> 1;
            state_in = ((size_ff >> 1) == '0) ? S_RESP : S_RP;
         end
         S_RP: begin
            if (slot_ff > (size_ff >> 1)) begin
               outer_in = outer_ff - SW'(1);
               slot_in = outer_ff - SW'(1);
               if (outer_ff == SW'(1)) state_in = S_RESP;
            end else begin
               rd_addr = slot_m1[AW-1:0];
               state_in = S_RL;
            end
         end
         S_RL: begin
            par_in = rd_data;
            rd_addr = adr(lc_slot);
            state_in = S_RR;
         end
         S_RR: begin
            lc_in = rd_data;
            rd_addr = adr(rc_slot);
            state_in = S_CMP;
         end
         S_CMP: begin
            logic use_r;
            mhpq_pkg::entry_type b;
            rc_in = rd_data;
            use_r = (rc_slot <= XW'(size_ff)) && (lc_ff.key < rd_data.key);
            b = use_r ? rd_data : lc_ff;
            big_in = use_r ? rc_slot[SW-1:0] : lc_slot[SW-1:0];
            if (par_ff.key < b.key) begin
               wr_en = 1'b1;
               wr_addr = slot_m1[AW-1:0];
               wr_data = b;
               rc_in = par_ff;
               state_in = S_WR2;
            end else begin
               outer_in = outer_ff - SW'(1);
               slot_in = outer_ff - SW'(1);
               state_in = (outer_ff == SW'(1)) ? S_RESP : S_RP;
            end
         end
         S_WR2: begin
            wr_en = 1'b1;
            wr_addr = adr(XW'(big_ff));
            wr_data = rc_ff;
            slot_in = big_ff;
            state_in = S_RP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_cnt_in = size_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      outer_ff <= outer_in;
      slot_ff <= slot_in;
      big_ff <= big_in;
      par_ff <= par_in;
      lc_ff <= lc_in;
      rc_ff <= rc_in;
      ent_ff <= ent_in;
      idx_ff <= idx_in;
      rsp_ent_ff <= rsp_ent_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_st_ff <= rsp_st_in;
   end
endmodule

/* rtl/mhpq_ram.sv */
module mhpq_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
